### design/cftr_pkg.sv
// cftr_pkg: shared types, constants and helpers for the can frame trace ring
// used by cftr_ctrl, cftr_dpath and can_frame_trace_ring
// no dependencies
package cftr_pkg;

  localparam int DefaultDepth  = 1024;
  localparam int CfgIndexW     = 4;
  localparam int CfgDataW      = 11;
  localparam int RingEntriesW  = 11;
  localparam int RowIndexW     = 10;
  localparam int StoredCountW  = 11;
  localparam int BytesPerFrame = 8;

  localparam logic [RingEntriesW-1:0] RingEntriesReset = 11'd1024;

  typedef enum logic [CfgIndexW-1:0] {
    REG_RING_ENTRIES = 4'd0,
    REG_FREEZE       = 4'd1
  } cfg_reg_e;

  // one stored trace row
  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] id;
    logic        extended;
    logic [3:0]  length;
    logic [63:0] data;
  } row_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } ctrl_cmd_t;

  // bytes at or past the length code are zeroed, codes above eight keep all
  function automatic logic [63:0] mask_data(input logic [3:0] len, input logic [63:0] data);
    logic [63:0] res;
    res = data;
    for (int b = 0; b < BytesPerFrame; b++) begin
      if (4'(b) >= len) begin
        res[b*8 +: 8] = 8'h00;
      end
    end
    return res;
  endfunction

endpackage

### design/cftr_ctrl.sv
// cftr_ctrl: sequencer for the can frame trace ring
// issues load, execute and respond commands to cftr_dpath; uses cftr_pkg
module cftr_ctrl
  import cftr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   exec_q;
  logic   respond_q;
  logic   accept;

  assign accept = start_i & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      busy_q    <= 1'b0;
      exec_q    <= 1'b0;
      respond_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE, ST_RESP: begin
          respond_q <= 1'b0;
          if (accept) begin
            state_q <= ST_EXEC;
            busy_q  <= 1'b1;
            exec_q  <= 1'b1;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_EXEC: begin
          // result shows in the next cycle, a new word may be taken alongside
          state_q   <= ST_RESP;
          busy_q    <= 1'b0;
          exec_q    <= 1'b0;
          respond_q <= 1'b1;
        end
        default: begin
          state_q   <= ST_IDLE;
          busy_q    <= 1'b0;
          exec_q    <= 1'b0;
          respond_q <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o        = busy_q;
  assign cmd_o.load    = accept;
  assign cmd_o.exec    = exec_q;
  assign cmd_o.respond = respond_q;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && exec_q))
    else $error("accepted word did not start execution");

  a_exec_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_q |=> (respond_q && !exec_q))
    else $error("execution not followed by a single result strobe");

  a_resp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    respond_q |=> !respond_q)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

### design/cftr_dpath.sv
// cftr_dpath: trace ring storage, head and count registers, config registers
// driven by cftr_ctrl commands; uses cftr_pkg
module cftr_dpath
  import cftr_pkg::*;
#(
  parameter int Depth = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIndexW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic                    command_i,
  input  logic [31:0]             timestamp_ms_i,
  input  logic [28:0]             frame_id_i,
  input  logic                    frame_extended_i,
  input  logic                    frame_remote_i,
  input  logic [3:0]              frame_length_i,
  input  logic [63:0]             frame_data_i,
  input  logic [RowIndexW-1:0]    row_index_i,
  output logic                    row_valid_o,
  output logic [31:0]             rec_time_o,
  output logic [15:0]             rec_id_o,
  output logic                    rec_extended_o,
  output logic [3:0]              rec_length_o,
  output logic [63:0]             rec_data_o,
  output logic [StoredCountW-1:0] stored_count_o,
  output logic [31:0]             total_count_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SW = $clog2(Depth + 1);
  localparam int CW = (SW > RingEntriesW) ? SW : RingEntriesW;
  localparam int PW = CW + 1;

  // config registers
  logic [RingEntriesW-1:0] ring_entries_q;
  logic                    freeze_q;

  // latched word
  logic                 read_q;
  logic                 remote_q;
  row_t                 in_row_q;
  logic [RowIndexW-1:0] row_q;

  // ring state
  logic [AW-1:0] head_q, head_d;
  logic          full_q, full_d;
  logic [31:0]   total_q;
  logic          hit_q;
  row_t          rd_q;

  row_t ring_mem [Depth];

  logic [SW-1:0] size_c;
  logic [SW-1:0] stored_c;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] head_inc;
  logic          cap_en;
  logic          hit_c;
  logic [PW-1:0] sum_c;
  logic [PW-1:0] pos_c;
  logic [AW-1:0] rd_addr;

  always_comb begin
    if (CW'(ring_entries_q) > CW'(Depth)) begin
      size_c = SW'(Depth);
    end else begin
      size_c = SW'(ring_entries_q);
    end
  end

  always_comb begin
    if (full_q) begin
      stored_c = size_c;
    end else if (SW'(head_q) < size_c) begin
      stored_c = SW'(head_q);
    end else begin
      stored_c = size_c;
    end
  end

  // capture path
  assign cap_en   = cmd_i.exec & ~read_q & (size_c != '0) & ~freeze_q & ~remote_q;
  assign wr_addr  = (SW'(head_q) < size_c) ? head_q : '0;
  assign head_inc = SW'(wr_addr) + SW'(1);

  always_comb begin
    head_d = head_q;
    full_d = full_q;
    if (head_inc >= size_c) begin
      head_d = '0;
      full_d = 1'b1;
    end else begin
      head_d = AW'(head_inc);
    end
  end

  // read path: oldest row sits at the head once the ring has wrapped
  assign hit_c = (size_c != '0) && (CW'(row_q) < CW'(stored_c));
  assign sum_c = PW'(full_q ? head_q : '0) + PW'(row_q);
  assign pos_c = (sum_c >= PW'(size_c)) ? (sum_c - PW'(size_c)) : sum_c;
  assign rd_addr = pos_c[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      read_q            <= command_i;
      remote_q          <= frame_remote_i;
      in_row_q.time_ms  <= timestamp_ms_i;
      in_row_q.id       <= frame_id_i[15:0];
      in_row_q.extended <= frame_extended_i;
      in_row_q.length   <= frame_length_i;
      in_row_q.data     <= mask_data(frame_length_i, frame_data_i);
      row_q             <= row_index_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_en) begin
      ring_mem[wr_addr] <= in_row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && read_q) begin
      rd_q <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_entries_q <= RingEntriesReset;
      freeze_q       <= 1'b0;
      head_q         <= '0;
      full_q         <= 1'b0;
      total_q        <= '0;
      hit_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_RING_ENTRIES) begin
          // resizing empties the ring, the total is kept
          ring_entries_q <= cfg_data_i[RingEntriesW-1:0];
          head_q         <= '0;
          full_q         <= 1'b0;
        end else if (cfg_index_i == REG_FREEZE) begin
          freeze_q <= cfg_data_i[0];
        end
      end
      if (cmd_i.exec) begin
        hit_q <= read_q & hit_c;
      end
      if (cap_en) begin
        head_q  <= head_d;
        full_q  <= full_d;
        total_q <= total_q + 32'd1;
      end
    end
  end

  assign row_valid_o    = hit_q;
  assign rec_time_o     = hit_q ? rd_q.time_ms  : '0;
  assign rec_id_o       = hit_q ? rd_q.id       : '0;
  assign rec_extended_o = hit_q ? rd_q.extended : 1'b0;
  assign rec_length_o   = hit_q ? rd_q.length   : '0;
  assign rec_data_o     = hit_q ? rd_q.data     : '0;
  assign stored_count_o = StoredCountW'(stored_c);
  assign total_count_o  = total_q;

`ifndef NO_ASSERTIONS
  a_head_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_c != '0) |-> (SW'(head_q) < size_c))
    else $error("write head outside the ring");

  a_full_needs_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (size_c != '0))
    else $error("ring marked full with no entries");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |-> (total_q == $past(total_q) + 32'd1))
    else $error("total count moved by more than one");
`endif

endmodule

### design/can_frame_trace_ring.sv
// can_frame_trace_ring: circular trace buffer for can frames, top level
// instantiates cftr_ctrl and cftr_dpath; uses cftr_pkg
//
//   channel   handshake                   payload
//   item      start_i / busy_o            command_i, timestamp_ms_i .. row_index_i
//   result    done_o (one-cycle strobe)   row_valid_o, rec_*_o, stored_count_o, total_count_o
//   config    cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// a word is executed in the cycle after it is taken (one ring memory access),
// its result strobes in the cycle after that. busy_o is high only during the
// execute cycle, so a new word can be taken while a result is shown. reset
// clears head, counts and flags; ring contents stay undefined and are never
// read before written. the receiver cannot stall.
module can_frame_trace_ring
  import cftr_pkg::*;
#(
  parameter int Depth = DefaultDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    command_i,
  input  logic [31:0]             timestamp_ms_i,
  input  logic [28:0]             frame_id_i,
  input  logic                    frame_extended_i,
  input  logic                    frame_remote_i,
  input  logic [3:0]              frame_length_i,
  input  logic [63:0]             frame_data_i,
  input  logic [RowIndexW-1:0]    row_index_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  output logic                    done_o,
  output logic                    row_valid_o,
  output logic [31:0]             rec_time_o,
  output logic [15:0]             rec_id_o,
  output logic                    rec_extended_o,
  output logic [3:0]              rec_length_o,
  output logic [63:0]             rec_data_o,
  output logic [StoredCountW-1:0] stored_count_o,
  output logic [31:0]             total_count_o
);

  ctrl_cmd_t cmd;
  logic      busy;

  cftr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  cftr_dpath #(
    .Depth(Depth)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .timestamp_ms_i  (timestamp_ms_i),
    .frame_id_i      (frame_id_i),
    .frame_extended_i(frame_extended_i),
    .frame_remote_i  (frame_remote_i),
    .frame_length_i  (frame_length_i),
    .frame_data_i    (frame_data_i),
    .row_index_i     (row_index_i),
    .row_valid_o     (row_valid_o),
    .rec_time_o      (rec_time_o),
    .rec_id_o        (rec_id_o),
    .rec_extended_o  (rec_extended_o),
    .rec_length_o    (rec_length_o),
    .rec_data_o      (rec_data_o),
    .stored_count_o  (stored_count_o),
    .total_count_o   (total_count_o)
  );

  assign busy_o      = busy;
  assign cfg_ready_o = ~busy;
  assign done_o      = cmd.respond;

endmodule
